// ----- design/cfpa_pkg.sv -----
// cfpa_pkg: widths, command codes, pipeline word types and saturation helpers
// for the complex fixed-point ALU. No dependencies.

package cfpa_pkg;

    localparam int DATA_W    = 32;              // Q16.16 word width
    localparam int FRAC_BITS = 16;              // fraction bits, 0..30
    localparam int CMD_W     = 3;
    localparam int PROD_W    = 2 * DATA_W;      // one full product
    localparam int SUM_W     = 2 * DATA_W + 2;  // exact sum of two products
    localparam int LIN_W     = DATA_W + 1;      // exact add/sub result
    localparam int RAD_W     = 2 * DATA_W;      // radicand for magnitude
    localparam int ROOT_W    = DATA_W;          // floor sqrt of radicand
    localparam int REM_W     = ROOT_W + 3;      // sqrt partial remainder
    localparam int SQ_STEPS  = 2;               // root bits per sqrt stage
    localparam int SQ_STAGES = ROOT_W / SQ_STEPS;
    localparam int LATENCY   = SQ_STAGES + 4;   // accept edge to result edge

    localparam logic [CMD_W-1:0] CMD_ADD  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADDR = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SUB  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MUL  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MAG  = 3'd4;

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // saturated value with its clip flag
    typedef struct packed {
        logic                     ovf;
        logic signed [DATA_W-1:0] val;
    } sat_t;

    // per-word results that ride alongside the square-root pipeline
    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [LIN_W-1:0]  lin_re;
        logic signed [LIN_W-1:0]  lin_im;
        logic signed [DATA_W-1:0] mul_re;
        logic signed [DATA_W-1:0] mul_im;
        logic                     mul_ovf;
    } side_t;

    // clip an exact add/sub result: out of range when the top two bits differ
    function automatic sat_t sat_lin(input logic signed [LIN_W-1:0] v);
        sat_t r;
        r.ovf = v[LIN_W-1] ^ v[LIN_W-2];
        if (!r.ovf)
            r.val = v[DATA_W-1:0];
        else if (v[LIN_W-1])
            r.val = SAT_MIN;
        else
            r.val = SAT_MAX;
        return r;
    endfunction

    // clip a shifted product sum: in range when bits above the word are sign copies
    function automatic sat_t sat_sum(input logic signed [SUM_W-1:0] v);
        sat_t r;
        r.ovf = !((&v[SUM_W-1:DATA_W-1]) || !(|v[SUM_W-1:DATA_W-1]));
        if (!r.ovf)
            r.val = v[DATA_W-1:0];
        else if (v[SUM_W-1])
            r.val = SAT_MIN;
        else
            r.val = SAT_MAX;
        return r;
    endfunction

endpackage

// ----- design/complex_fixed_point_alu.sv -----
// complex_fixed_point_alu: top level of the Q16.16 complex arithmetic unit.
// Depends on cfpa_pkg, cfpa_arith, cfpa_sqrt and cfpa_out.
//
// Usage:
//   Command channel: drive cmd, a_re, a_im, b_re, b_im and raise start; the word
//   is taken at the rising edge where start is high and busy is low. busy is
//   held low, so a new word can go in on every clock.
//   Commands: add, add real (b_re only), subtract, multiply, magnitude of a.
//   Result channel: r_re, r_im and overflow are valid for exactly one cycle
//   while done is high. The receiver has no way to hold results off, so the
//   pipeline never stalls and every word comes out in order.
// Throughput: one word per clock. The latency is set by the magnitude path:
//   a 16-stage square-root pipeline that resolves two root bits per stage;
//   all other commands ride alongside it so results stay in order.
// Stages: input register, four 32x32 multipliers, product sum with shift and
//   clip, 16 square-root stages, output select and register.
// Reset: rst_n clears all valid bits at once; data in flight is dropped and
//   no done strobe is given for it. Data registers are not reset.

module complex_fixed_point_alu import cfpa_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [CMD_W-1:0]         cmd,
    input  logic signed [DATA_W-1:0] a_re,
    input  logic signed [DATA_W-1:0] a_im,
    input  logic signed [DATA_W-1:0] b_re,
    input  logic signed [DATA_W-1:0] b_im,
    output logic                     done,
    output logic signed [DATA_W-1:0] r_re,
    output logic signed [DATA_W-1:0] r_im,
    output logic                     overflow
);

    logic              accept;
    logic              ar_valid;
    side_t             ar_side;
    logic [RAD_W-1:0]  ar_rad;
    logic              sq_valid;
    side_t             sq_side;
    logic [ROOT_W-1:0] sq_root;

    // fully pipelined: never refuses a word
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // operand capture, multiplies, product sums
    cfpa_arith u_arith (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .cmd       (cmd),
        .a_re      (a_re),
        .a_im      (a_im),
        .b_re      (b_re),
        .b_im      (b_im),
        .out_valid (ar_valid),
        .out_side  (ar_side),
        .out_rad   (ar_rad)
    );

    // floor sqrt of a_re^2 + a_im^2; side results delayed to match
    cfpa_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ar_valid),
        .in_side   (ar_side),
        .in_rad    (ar_rad),
        .out_valid (sq_valid),
        .out_side  (sq_side),
        .out_root  (sq_root)
    );

    // pick result per command, clip, register outputs
    cfpa_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sq_valid),
        .in_side  (sq_side),
        .in_root  (sq_root),
        .done     (done),
        .r_re     (r_re),
        .r_im     (r_im),
        .overflow (overflow)
    );

endmodule

// ----- design/cfpa_arith.sv -----
// cfpa_arith: input register, multiplier stage and product-sum stage.
// Depends on cfpa_pkg.

module cfpa_arith import cfpa_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [CMD_W-1:0]         cmd,
    input  logic signed [DATA_W-1:0] a_re,
    input  logic signed [DATA_W-1:0] a_im,
    input  logic signed [DATA_W-1:0] b_re,
    input  logic signed [DATA_W-1:0] b_im,
    output logic                     out_valid,
    output side_t                    out_side,
    output logic [RAD_W-1:0]         out_rad
);

    // stage A: operand capture
    logic                     a_valid_reg;
    logic [CMD_W-1:0]         a_cmd_reg;
    logic signed [DATA_W-1:0] ar_reg, ai_reg, br_reg, bi_reg;

    // stage B: products and exact linear results
    logic                     b_valid_reg;
    logic [CMD_W-1:0]         b_cmd_reg;
    logic signed [PROD_W-1:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [PROD_W-1:0] p0_next, p1_next, p2_next, p3_next;
    logic signed [LIN_W-1:0]  lin_re_reg, lin_im_reg, lin_re_next, lin_im_next;
    logic signed [DATA_W-1:0] m0_op, m1_op;

    // stage C: product sums, shift and clip
    logic                     c_valid_reg;
    side_t                    c_side_reg, c_side_next;
    logic [RAD_W-1:0]         c_rad_reg, c_rad_next;
    logic signed [SUM_W-1:0]  re_sum, im_sum;
    sat_t                     re_sat, im_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_cmd_reg <= cmd;
        ar_reg    <= a_re;
        ai_reg    <= a_im;
        br_reg    <= b_re;
        bi_reg    <= b_im;
    end

    // magnitude reuses the first two multipliers for a_re^2 and a_im^2
    always_comb
    begin
        m0_op   = (a_cmd_reg == CMD_MAG) ? ar_reg : br_reg;
        m1_op   = (a_cmd_reg == CMD_MAG) ? ai_reg : bi_reg;
        p0_next = ar_reg * m0_op;
        p1_next = ai_reg * m1_op;
        p2_next = ar_reg * bi_reg;
        p3_next = ai_reg * br_reg;
        case (a_cmd_reg)
            CMD_SUB:
            begin
                lin_re_next = LIN_W'(ar_reg) - LIN_W'(br_reg);
                lin_im_next = LIN_W'(ai_reg) - LIN_W'(bi_reg);
            end
            CMD_ADDR:
            begin
                lin_re_next = LIN_W'(ar_reg) + LIN_W'(br_reg);
                lin_im_next = LIN_W'(ai_reg);
            end
            default:
            begin
                lin_re_next = LIN_W'(ar_reg) + LIN_W'(br_reg);
                lin_im_next = LIN_W'(ai_reg) + LIN_W'(bi_reg);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        b_cmd_reg  <= a_cmd_reg;
        p0_reg     <= p0_next;
        p1_reg     <= p1_next;
        p2_reg     <= p2_next;
        p3_reg     <= p3_next;
        lin_re_reg <= lin_re_next;
        lin_im_reg <= lin_im_next;
    end

    always_comb
    begin
        re_sum              = (SUM_W'(p0_reg) - SUM_W'(p1_reg)) >>> FRAC_BITS;
        im_sum              = (SUM_W'(p2_reg) + SUM_W'(p3_reg)) >>> FRAC_BITS;
        re_sat              = sat_sum(re_sum);
        im_sat              = sat_sum(im_sum);
        c_side_next.cmd     = b_cmd_reg;
        c_side_next.lin_re  = lin_re_reg;
        c_side_next.lin_im  = lin_im_reg;
        c_side_next.mul_re  = re_sat.val;
        c_side_next.mul_im  = im_sat.val;
        c_side_next.mul_ovf = re_sat.ovf | im_sat.ovf;
        // both squares are at most 2^62, so the sum fits unsigned
        c_rad_next          = $unsigned(p0_reg) + $unsigned(p1_reg);
    end

    always_ff @(posedge clk)
    begin
        c_side_reg <= c_side_next;
        c_rad_reg  <= c_rad_next;
    end

    assign out_valid = c_valid_reg;
    assign out_side  = c_side_reg;
    assign out_rad   = c_rad_reg;

endmodule

// ----- design/cfpa_sqrt.sv -----
// cfpa_sqrt: pipelined digit-by-digit floor square root, two root bits per stage,
// carrying the side results along. Depends on cfpa_pkg.

module cfpa_sqrt import cfpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  side_t             in_side,
    input  logic [RAD_W-1:0]  in_rad,
    output logic              out_valid,
    output side_t             out_side,
    output logic [ROOT_W-1:0] out_root
);

    logic              valid_reg [SQ_STAGES];
    side_t             side_reg  [SQ_STAGES];
    logic [REM_W-1:0]  rem_reg   [SQ_STAGES];
    logic [ROOT_W-1:0] root_reg  [SQ_STAGES];
    logic [RAD_W-1:0]  rad_reg   [SQ_STAGES];

    logic              valid_in  [SQ_STAGES];
    side_t             side_in   [SQ_STAGES];
    logic [REM_W-1:0]  rem_in    [SQ_STAGES];
    logic [ROOT_W-1:0] root_in   [SQ_STAGES];
    logic [RAD_W-1:0]  rad_in    [SQ_STAGES];

    logic [REM_W-1:0]  rem_next  [SQ_STAGES];
    logic [ROOT_W-1:0] root_next [SQ_STAGES];
    logic [RAD_W-1:0]  rad_next  [SQ_STAGES];

    for (genvar s = 0; s < SQ_STAGES; s++)
    begin : g_stage
        if (s == 0)
        begin : g_first
            assign valid_in[s] = in_valid;
            assign side_in[s]  = in_side;
            assign rem_in[s]   = '0;
            assign root_in[s]  = '0;
            assign rad_in[s]   = in_rad;
        end
        else
        begin : g_rest
            assign valid_in[s] = valid_reg[s-1];
            assign side_in[s]  = side_reg[s-1];
            assign rem_in[s]   = rem_reg[s-1];
            assign root_in[s]  = root_reg[s-1];
            assign rad_in[s]   = rad_reg[s-1];
        end

        // per root bit: bring down two radicand bits, try (root << 2) | 1 against the remainder
        always_comb
        begin : p_step
            logic [REM_W-1:0]  rem;
            logic [REM_W-1:0]  trial;
            logic [ROOT_W-1:0] root;
            logic [RAD_W-1:0]  rad;
            rem  = rem_in[s];
            root = root_in[s];
            rad  = rad_in[s];
            for (int k = 0; k < SQ_STEPS; k++)
            begin
                rem   = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
                rad   = {rad[RAD_W-3:0], 2'b00};
                trial = {1'b0, root, 2'b01};
                if (rem >= trial)
                begin
                    rem  = rem - trial;
                    root = {root[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    root = {root[ROOT_W-2:0], 1'b0};
                end
            end
            rem_next[s]  = rem;
            root_next[s] = root;
            rad_next[s]  = rad;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else
                valid_reg[s] <= valid_in[s];
        end

        always_ff @(posedge clk)
        begin
            side_reg[s] <= side_in[s];
            rem_reg[s]  <= rem_next[s];
            root_reg[s] <= root_next[s];
            rad_reg[s]  <= rad_next[s];
        end
    end

    assign out_valid = valid_reg[SQ_STAGES-1];
    assign out_side  = side_reg[SQ_STAGES-1];
    assign out_root  = root_reg[SQ_STAGES-1];

endmodule

// ----- design/cfpa_out.sv -----
// cfpa_out: per-command result select, final clip and output register.
// Depends on cfpa_pkg.

module cfpa_out import cfpa_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  side_t                    in_side,
    input  logic [ROOT_W-1:0]        in_root,
    output logic                     done,
    output logic signed [DATA_W-1:0] r_re,
    output logic signed [DATA_W-1:0] r_im,
    output logic                     overflow
);

    logic                     done_reg;
    logic signed [DATA_W-1:0] r_re_reg, r_re_next, r_im_reg, r_im_next;
    logic                     ovf_reg, ovf_next;
    sat_t                     lin_re_sat, lin_im_sat;

    always_comb
    begin
        lin_re_sat = sat_lin(in_side.lin_re);
        lin_im_sat = sat_lin(in_side.lin_im);
        case (in_side.cmd) inside
            CMD_ADD, CMD_ADDR, CMD_SUB:
            begin
                r_re_next = lin_re_sat.val;
                r_im_next = lin_im_sat.val;
                ovf_next  = lin_re_sat.ovf | lin_im_sat.ovf;
            end
            CMD_MUL:
            begin
                r_re_next = in_side.mul_re;
                r_im_next = in_side.mul_im;
                ovf_next  = in_side.mul_ovf;
            end
            CMD_MAG:
            begin
                // root can reach about 1.41 * 2^31: clip at the top bit
                r_re_next = in_root[ROOT_W-1] ? SAT_MAX : $signed(in_root);
                r_im_next = '0;
                ovf_next  = in_root[ROOT_W-1];
            end
            default:
            begin
                r_re_next = '0;
                r_im_next = '0;
                ovf_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        r_re_reg <= r_re_next;
        r_im_reg <= r_im_next;
        ovf_reg  <= ovf_next;
    end

    assign done     = done_reg;
    assign r_re     = r_re_reg;
    assign r_im     = r_im_reg;
    assign overflow = ovf_reg;

endmodule

// ----- design/cfpa_checker.sv -----
// cfpa_checker: port-level checks on the complex ALU, attached by bind.
// Depends on cfpa_pkg and complex_fixed_point_alu.

module cfpa_checker import cfpa_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     start,
    input logic                     busy,
    input logic [CMD_W-1:0]         cmd,
    input logic signed [DATA_W-1:0] a_im,
    input logic                     done,
    input logic signed [DATA_W-1:0] r_re,
    input logic signed [DATA_W-1:0] r_im,
    input logic                     overflow
);

    localparam int CNT_W = $clog2(LATENCY + 1);

    // cycles since reset release, saturating at the pipeline depth
    logic [CNT_W-1:0] up_cnt_reg, up_cnt_next;
    logic             warm;

    assign warm        = (up_cnt_reg == CNT_W'(LATENCY));
    assign up_cnt_next = warm ? up_cnt_reg : up_cnt_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            up_cnt_reg <= '0;
        else
            up_cnt_reg <= up_cnt_next;
    end

    // one strobe per accepted word, a fixed depth later
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        warm |-> (done == $past(start && !busy, LATENCY)))
        else $error("done does not track accepted words at the pipeline depth");

    a_mag: assert property (@(posedge clk) disable iff (!rst_n)
        (warm && done && $past(cmd == CMD_MAG, LATENCY))
        |-> (r_im == '0 && !r_re[DATA_W-1]))
        else $error("magnitude result has nonzero imaginary part or is negative");

    a_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (warm && done && $past(cmd == CMD_ADDR, LATENCY))
        |-> (r_im == $past(a_im, LATENCY)))
        else $error("add real changed the imaginary part");

    a_unused: assert property (@(posedge clk) disable iff (!rst_n)
        (warm && done && $past(cmd > CMD_MAG, LATENCY))
        |-> (r_re == '0 && r_im == '0 && !overflow))
        else $error("unused command gave a nonzero result");

endmodule

bind complex_fixed_point_alu cfpa_checker u_cfpa_checker (.*);

// ----- dv/complex_fixed_point_alu_test.sv -----
`timescale 1ns / 100ps
// complex_fixed_point_alu_test: self-checking bench for the Q16.16 complex ALU.
// Directed table, then random words, checked against an in-bench predictor.
// Depends on cfpa_pkg and complex_fixed_point_alu.

module complex_fixed_point_alu_test;
    import cfpa_pkg::*;

    // commands with no operation behind them; the block returns all zeros
    localparam logic [CMD_W-1:0] CMD_RSV5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSV6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSV7 = 3'd7;

    localparam int WIDE_W       = 2 * DATA_W + 2;  // holds any exact sum of two products
    localparam int RAND_WORDS   = 1200;
    localparam int QUIET_FIRST  = 300;             // no sender gaps in [QUIET_FIRST, QUIET_LAST)
    localparam int QUIET_LAST   = 550;
    localparam int DRAIN_AT     = 700;             // sender holds off until pipe is empty
    localparam int STALL_LIMIT  = 1000;            // cycles with no word moving either way

    localparam logic signed [WIDE_W-1:0] WIDE_MAX = SAT_MAX;
    localparam logic signed [WIDE_W-1:0] WIDE_MIN = SAT_MIN;

    typedef struct packed {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
        logic                     ovf;
    } cplx_res_t;

    typedef struct packed {
        logic                     clip;
        logic signed [DATA_W-1:0] val;
    } clamp_t;

    // one row of the directed table; "typed" rows carry a hand-written answer
    typedef struct packed {
        logic [CMD_W-1:0]         op;
        logic signed [DATA_W-1:0] ar;
        logic signed [DATA_W-1:0] ai;
        logic signed [DATA_W-1:0] br;
        logic signed [DATA_W-1:0] bi;
        logic                     typed;
        cplx_res_t                want;
    } stim_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] a_re;
    logic signed [DATA_W-1:0] a_im;
    logic signed [DATA_W-1:0] b_re;
    logic signed [DATA_W-1:0] b_im;
    logic                     done;
    logic signed [DATA_W-1:0] r_re;
    logic signed [DATA_W-1:0] r_im;
    logic                     overflow;

    // bench-side tag that rides along with the word on the command port
    logic                     word_typed;
    cplx_res_t                word_want;

    cplx_res_t                expected_results[$];
    stim_row_t                dir_table[$];
    int                       fail_count;
    int                       stall_cycles;

    complex_fixed_point_alu u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .a_re     (a_re),
        .a_im     (a_im),
        .b_re     (b_re),
        .b_im     (b_im),
        .done     (done),
        .r_re     (r_re),
        .r_im     (r_im),
        .overflow (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Predictor: exact wide arithmetic, then clip to the Q16.16 word.
    // ---------------------------------------------------------------
    function automatic clamp_t clamp_word(input logic signed [WIDE_W-1:0] v);
        clamp_t c;
        c.clip = 1'b1;
        if (v > WIDE_MAX)
            c.val = SAT_MAX;
        else if (v < WIDE_MIN)
            c.val = SAT_MIN;
        else
        begin
            c.clip = 1'b0;
            c.val  = v[DATA_W-1:0];
        end
        return c;
    endfunction

    function automatic cplx_res_t cplx_predict(input logic [CMD_W-1:0] op,
                                               input logic signed [DATA_W-1:0] ar,
                                               input logic signed [DATA_W-1:0] ai,
                                               input logic signed [DATA_W-1:0] br,
                                               input logic signed [DATA_W-1:0] bi);
        logic signed [WIDE_W-1:0] xa, ya, xb, yb;
        logic [2*DATA_W-1:0]      mag_re, mag_im, radicand;
        logic [DATA_W-1:0]        root, trial;
        clamp_t                   part_re, part_im;
        cplx_res_t                res;
        int                       k;
        xa      = ar;
        ya      = ai;
        xb      = br;
        yb      = bi;
        part_re = '0;
        part_im = '0;
        case (op)
            CMD_ADD:
            begin
                part_re = clamp_word(xa + xb);
                part_im = clamp_word(ya + yb);
            end
            CMD_ADDR:
            begin
                part_re     = clamp_word(xa + xb);
                part_im.val = ai;
            end
            CMD_SUB:
            begin
                part_re = clamp_word(xa - xb);
                part_im = clamp_word(ya - yb);
            end
            CMD_MUL:
            begin
                // >>> on a signed sum floors toward minus infinity
                part_re = clamp_word((xa * xb - ya * yb) >>> FRAC_BITS);
                part_im = clamp_word((xa * yb + ya * xb) >>> FRAC_BITS);
            end
            CMD_MAG:
            begin
                if (xa < 0)
                    xa = -xa;
                if (ya < 0)
                    ya = -ya;
                mag_re   = xa[2*DATA_W-1:0];
                mag_im   = ya[2*DATA_W-1:0];
                radicand = mag_re * mag_re + mag_im * mag_im;
                // floor square root, one bit at a time from the top
                root = '0;
                for (k = DATA_W - 1; k >= 0; k--)
                begin
                    trial = root | (32'd1 << k);
                    if ({32'd0, trial} * {32'd0, trial} <= radicand)
                        root = trial;
                end
                if (root[DATA_W-1])
                begin
                    part_re.clip = 1'b1;
                    part_re.val  = SAT_MAX;
                end
                else
                    part_re.val = root;
            end
            default: ;
        endcase
        res.re  = part_re.val;
        res.im  = part_im.val;
        res.ovf = part_re.clip | part_im.clip;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic stim_row_t dir_row(input logic [CMD_W-1:0] op,
                                          input logic signed [DATA_W-1:0] ar,
                                          input logic signed [DATA_W-1:0] ai,
                                          input logic signed [DATA_W-1:0] br,
                                          input logic signed [DATA_W-1:0] bi,
                                          input logic typed,
                                          input logic signed [DATA_W-1:0] re,
                                          input logic signed [DATA_W-1:0] im,
                                          input logic ovf);
        stim_row_t row;
        row.op       = op;
        row.ar       = ar;
        row.ai       = ai;
        row.br       = br;
        row.bi       = bi;
        row.typed    = typed;
        row.want.re  = re;
        row.want.im  = im;
        row.want.ovf = ovf;
        return row;
    endfunction

    // mix of extremes, near-zero values (so products stay in range) and full range
    function automatic logic signed [DATA_W-1:0] rand_operand();
        logic signed [19:0]       near;
        logic signed [DATA_W-1:0] v;
        near = 20'($urandom);
        case ($urandom_range(0, 9))
            0:       v = SAT_MAX;
            1:       v = SAT_MIN;
            2:       v = $urandom_range(0, 2) - 1;
            3, 4, 5: v = near;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [CMD_W-1:0] rand_cmd();
        logic [CMD_W-1:0] op;
        if ($urandom_range(0, 99) < 90)
            op = CMD_W'($urandom_range(CMD_ADD, CMD_MAG));
        else
            op = CMD_W'($urandom_range(CMD_RSV5, CMD_RSV7));
        return op;
    endfunction

    // idle: start low while data ports carry junk the block must ignore
    task automatic idle_cycle();
        start      <= 1'b0;
        cmd        <= CMD_W'($urandom);
        a_re       <= $urandom;
        a_im       <= $urandom;
        b_re       <= $urandom;
        b_im       <= $urandom;
        word_typed <= 1'b0;
        @(posedge clk);
    endtask

    task automatic sender_gap();
        while ($urandom_range(0, 99) < 32)
            idle_cycle();
    endtask

    // present a word and hold it until the accepting edge
    task automatic issue_word(input stim_row_t row);
        start      <= 1'b1;
        cmd        <= row.op;
        a_re       <= row.ar;
        a_im       <= row.ai;
        b_re       <= row.br;
        b_im       <= row.bi;
        word_typed <= row.typed;
        word_want  <= row.want;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic report_fail(input string msg);
        fail_count++;
        $display("%s", msg);
    endtask

    // ---------------------------------------------------------------
    // Monitor: predict on accept, check on done. Both sample pre-edge values.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        cplx_res_t exp_res;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                if (word_typed)
                    expected_results.push_back(word_want);
                else
                    expected_results.push_back(cplx_predict(cmd, a_re, a_im, b_re, b_im));
            end
            if (done)
            begin
                if (expected_results.size() == 0)
                    report_fail($sformatf("%0t: result with none expected: r_re %h r_im %h ovf %b",
                                          $realtime, r_re, r_im, overflow));
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (r_re !== exp_res.re)
                        report_fail($sformatf("%0t: r_re expected %h actual %h",
                                              $realtime, exp_res.re, r_re));
                    if (r_im !== exp_res.im)
                        report_fail($sformatf("%0t: r_im expected %h actual %h",
                                              $realtime, exp_res.im, r_im));
                    if (overflow !== exp_res.ovf)
                        report_fail($sformatf("%0t: overflow expected %b actual %b",
                                              $realtime, exp_res.ovf, overflow));
                end
            end
        end
    end

    // watchdog: nothing moving on either port for too long ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("complex_fixed_point_alu verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        int n;
        fail_count   = 0;
        stall_cycles = 0;
        rst_n      <= 1'b0;
        start      <= 1'b0;
        cmd        <= CMD_ADD;
        a_re       <= '0;
        a_im       <= '0;
        b_re       <= '0;
        b_im       <= '0;
        word_typed <= 1'b0;
        word_want  <= '0;

        // directed table: op, a_re, a_im, b_re, b_im, typed, r_re, r_im, overflow
        // add: both parts clip high, both clip low, then a plain sum
        dir_table.push_back(dir_row(CMD_ADD, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, 1'b1,
                                    SAT_MAX, SAT_MAX, 1'b1));
        dir_table.push_back(dir_row(CMD_ADD, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, 1'b1,
                                    SAT_MIN, SAT_MIN, 1'b1));
        dir_table.push_back(dir_row(CMD_ADD, 32'sh10000, 32'sh20000, 32'sh30000, -32'sh10000,
                                    1'b1, 32'sh40000, 32'sh10000, 1'b0));
        // add real: imaginary passes through untouched even beside a clipped real part
        dir_table.push_back(dir_row(CMD_ADDR, SAT_MAX, SAT_MIN, 32'sd1, SAT_MAX, 1'b1,
                                    SAT_MAX, SAT_MIN, 1'b1));
        dir_table.push_back(dir_row(CMD_ADDR, 32'sd1, 32'sd2, 32'sd3, SAT_MAX, 1'b1,
                                    32'sd4, 32'sd2, 1'b0));
        // subtract: 0 - MIN clips high, MIN - 1 clips low
        dir_table.push_back(dir_row(CMD_SUB, 32'sd0, SAT_MIN, SAT_MIN, 32'sd0, 1'b1,
                                    SAT_MAX, SAT_MIN, 1'b1));
        dir_table.push_back(dir_row(CMD_SUB, SAT_MIN, SAT_MAX, 32'sd1, -32'sd1, 1'b1,
                                    SAT_MIN, SAT_MAX, 1'b1));
        dir_table.push_back(dir_row(CMD_SUB, 32'sd5, -32'sd5, 32'sd5, -32'sd5, 1'b1,
                                    32'sd0, 32'sd0, 1'b0));
        // multiply: 1.0 * 1.0, floor of a tiny negative product, widest product sum
        dir_table.push_back(dir_row(CMD_MUL, 32'sh10000, 32'sd0, 32'sh10000, 32'sd0, 1'b1,
                                    32'sh10000, 32'sd0, 1'b0));
        dir_table.push_back(dir_row(CMD_MUL, -32'sd1, 32'sd0, 32'sd1, 32'sd0, 1'b1,
                                    -32'sd1, 32'sd0, 1'b0));
        dir_table.push_back(dir_row(CMD_MUL, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, 1'b1,
                                    32'sd0, SAT_MAX, 1'b1));
        dir_table.push_back(dir_row(CMD_MUL, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MIN, 1'b0,
                                    '0, '0, 1'b0));
        dir_table.push_back(dir_row(CMD_MUL, 32'sh18000, -32'sh8000, 32'sh20000, 32'sh4000,
                                    1'b0, '0, '0, 1'b0));
        dir_table.push_back(dir_row(CMD_MUL, -32'sh10001, 32'sh7fff, -32'sh3, 32'sh12345,
                                    1'b0, '0, '0, 1'b0));
        // magnitude: b is junk and must not matter; |MIN| alone already clips
        dir_table.push_back(dir_row(CMD_MAG, 32'sd3, 32'sd4, SAT_MIN, SAT_MAX, 1'b1,
                                    32'sd5, 32'sd0, 1'b0));
        dir_table.push_back(dir_row(CMD_MAG, -32'sd3, -32'sd4, 32'sd7, 32'sd9, 1'b1,
                                    32'sd5, 32'sd0, 1'b0));
        dir_table.push_back(dir_row(CMD_MAG, SAT_MIN, SAT_MIN, 32'sd0, 32'sd0, 1'b1,
                                    SAT_MAX, 32'sd0, 1'b1));
        dir_table.push_back(dir_row(CMD_MAG, SAT_MIN, 32'sd0, 32'sd0, 32'sd0, 1'b1,
                                    SAT_MAX, 32'sd0, 1'b1));
        dir_table.push_back(dir_row(CMD_MAG, SAT_MAX, 32'sd0, 32'sd1, 32'sd1, 1'b1,
                                    SAT_MAX, 32'sd0, 1'b0));
        dir_table.push_back(dir_row(CMD_MAG, 32'sd0, 32'sd0, SAT_MAX, SAT_MIN, 1'b1,
                                    32'sd0, 32'sd0, 1'b0));
        dir_table.push_back(dir_row(CMD_MAG, 32'sh12345678, -32'shabcdef0, 32'sd0, 32'sd0,
                                    1'b0, '0, '0, 1'b0));
        // unused codes give all zeros, no overflow
        dir_table.push_back(dir_row(CMD_RSV5, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, 1'b1,
                                    32'sd0, 32'sd0, 1'b0));
        dir_table.push_back(dir_row(CMD_RSV6, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, 1'b1,
                                    32'sd0, 32'sd0, 1'b0));
        dir_table.push_back(dir_row(CMD_RSV7, -32'sd1, 32'sd1, -32'sd1, 32'sd1, 1'b1,
                                    32'sd0, 32'sd0, 1'b0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[i])
        begin
            sender_gap();
            issue_word(dir_table[i]);
        end

        for (n = 0; n < RAND_WORDS; n++)
        begin
            // let the pipe run dry once, then restart from empty
            if (n == DRAIN_AT)
                while (expected_results.size() != 0)
                    idle_cycle();
            // back-to-back stretch in the middle, random gaps elsewhere
            if (n < QUIET_FIRST || n >= QUIET_LAST)
                sender_gap();
            issue_word(dir_row(rand_cmd(), rand_operand(), rand_operand(),
                               rand_operand(), rand_operand(), 1'b0, '0, '0, 1'b0));
        end

        // drain, then watch a while for stray done strobes
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);

        if (fail_count == 0)
            $display("complex_fixed_point_alu verification clean");
        else
            $display("complex_fixed_point_alu verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
design/cfpa_pkg.sv
design/cfpa_arith.sv
design/cfpa_sqrt.sv
design/cfpa_out.sv
design/complex_fixed_point_alu.sv
design/cfpa_checker.sv
dv/complex_fixed_point_alu_test.sv
